// ===== rtl/core/tscrm_pkg.sv =====
package tscrm_pkg;

   localparam logic       FUNC_READ        = 1'b0;
   localparam logic       FUNC_WRITE       = 1'b1;

   localparam logic [2:0] STATUS_IN_PROG   = 3'd0;
   localparam logic [2:0] STATUS_COMMITTED = 3'd1;
   localparam logic [2:0] STATUS_ABORTED   = 3'd2;
   localparam logic [2:0] STATUS_FROZEN    = 3'd3;

   localparam logic [62:0] MARK_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic        func;
      logic [3:0]  zone_id;
      logic [62:0] slot_id;
      logic [62:0] record_tag;
      logic [63:0] record_csn;
      logic [2:0]  record_status;
      logic [63:0] recycle_min;
      logic        keep_in_progress;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [2:0]  found_status;
      logic [63:0] found_csn;
      logic [62:0] found_tag;
      logic [62:0] zone_watermark;
   } rsp_type;

   typedef struct packed {
      logic [63:0] csn;
      logic [62:0] tag;
      logic [2:0]  status;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_EVAL
   } state_type;

endpackage

// ===== rtl/core/txn_status_cache_with_recycle_mark_core.sv =====
// Per-zone direct-mapped cache of transaction outcomes with a monotonic recycle
// watermark per zone. Entries (csn, tag, status) sit in one synchronous memory of
// ZONES*SLOTS rows, the watermarks in a second memory of ZONES rows; each transaction
// reads both, then writes back once the output register is free. With SLOTS a power
// of two a transaction is a memory read, then a read-modify-write. Otherwise the slot
// id is first reduced mod SLOTS 16 bits per step, each step a quotient by reciprocal
// multiply, then a remainder by multiply and subtract. The result sits in an output
// register, so the next transaction is taken while the previous result waits; a
// transaction stalls in its write-back cycle only while that register is full and
// rsp_ready is low. After reset a clearing pass zeroes both memories; req_ready stays
// low until it ends.
module txn_status_cache_with_recycle_mark_core
   import tscrm_pkg::*;
#(
   parameter int ZONES = 16,
   parameter int SLOTS = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int DEPTH      = ZONES * SLOTS;
   localparam int AW         = $clog2(DEPTH);
   localparam int ZW         = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int SW         = $clog2(SLOTS);
   localparam bit SLOT_POW2  = ((SLOTS & (SLOTS - 1)) == 0);
   localparam int CHUNK      = 16;
   localparam int MOD_CYCLES = 2 * (64 / CHUNK);
   localparam int CW         = $clog2(MOD_CYCLES);
   localparam int RSH        = 32 + SW;
   localparam logic [32:0]   RECIP     =
      33'(((64'd1 << RSH) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
   localparam logic [31:0]   SLOTS_W   = 32'(SLOTS);
   localparam logic [AW-1:0] SLOTS_A   = AW'(SLOTS);
   localparam logic [AW-1:0] ZONES_A   = AW'(ZONES);
   localparam logic [AW-1:0] LAST_ROW  = AW'(DEPTH - 1);
   localparam logic [CW-1:0] LAST_CNT  = CW'(MOD_CYCLES - 1);

   // memories
   entry_type   ent_mem [DEPTH];
   logic [62:0] wm_mem  [ZONES];

   state_type   state_ff, state_in;
   logic        clear_ff;
   logic [AW-1:0] clear_cnt_ff;
   req_type     req_ff;
   logic [ZW-1:0] zone_ff;
   logic [AW-1:0] addr_ff;
   entry_type   ent_rd_ff;
   logic [62:0] wm_rd_ff;
   logic [SW-1:0] rem_ff, rem_in;
   logic [63:0] shift_ff;
   logic [CW-1:0] mod_cnt_ff;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] mod_x, mod_qd, mod_diff;
   logic [64:0] mod_prod;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        accept, rsp_free, eval_go, rd_en, mod_start, mod_run;
   logic [ZW-1:0] zone_mod;
   logic [AW-1:0] idle_addr, read_addr, rd_addr;
   logic [ZW-1:0] wm_rd_addr;

   logic        ent_wr_en, wm_wr_en;
   logic [AW-1:0] ent_wr_addr;
   entry_type   ent_wr_data;
   logic [ZW-1:0] wm_wr_addr;
   logic [62:0] wm_wr_data;

   logic        is_read, is_final, frozen, tag_hit, raise, store;
   logic [62:0] mark_next, wm_new;
   rsp_type     rsp_new;
   entry_type   ent_new;

   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // zone id taken modulo ZONES
   always_comb begin
      zone_mod = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_data.zone_id == 4'(i)) begin
            zone_mod = ZW'(i % ZONES);
         end
      end
   end

   assign idle_addr  = AW'(zone_mod) * SLOTS_A + AW'(req_data.slot_id[SW-1:0]);
   assign read_addr  = AW'(zone_ff) * SLOTS_A + AW'(rem_ff);
   assign rd_addr    = (state_ff == ST_IDLE) ? idle_addr : read_addr;
   assign wm_rd_addr = (state_ff == ST_IDLE) ? zone_mod : zone_ff;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rd_en     = 1'b0;
      mod_start = 1'b0;
      mod_run   = 1'b0;
      eval_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !clear_ff;
            if (req_valid && !clear_ff) begin
               if (SLOT_POW2) begin
                  rd_en    = 1'b1;
                  state_in = ST_EVAL;
               end else begin
                  mod_start = 1'b1;
                  state_in  = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            mod_run = 1'b1;
            if (mod_cnt_ff == LAST_CNT) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (rsp_free) begin
               eval_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // slot id mod SLOTS, 16 bits per step msb first: quotient of {remainder, chunk}
   // by reciprocal multiply, then the new remainder in the following cycle
   always_comb begin
      mod_x    = {16'(rem_ff), shift_ff[63:48]};
      mod_prod = {33'd0, mod_x} * {32'd0, RECIP};
      quo_in   = 32'(mod_prod >> RSH);
      mod_qd   = quo_ff * SLOTS_W;
      mod_diff = mod_x - mod_qd;
      rem_in   = mod_diff[SW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mod_start) begin
         rem_ff     <= '0;
         shift_ff   <= {1'b0, req_data.slot_id};
         mod_cnt_ff <= '0;
      end else if (mod_run) begin
         if (!mod_cnt_ff[0]) begin
            quo_ff <= quo_in;
         end else begin
            rem_ff   <= rem_in;
            shift_ff <= shift_ff << CHUNK;
         end
         mod_cnt_ff <= mod_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff  <= req_data;
         zone_ff <= zone_mod;
      end
      if (rd_en) begin
         addr_ff <= rd_addr;
      end
   end

   // read-modify-write evaluation
   always_comb begin
      is_read   = (req_ff.func == FUNC_READ);
      is_final  = (req_ff.record_status == STATUS_COMMITTED) ||
                  (req_ff.record_status == STATUS_ABORTED) ||
                  (req_ff.record_status == STATUS_FROZEN);
      frozen    = (req_ff.slot_id < wm_rd_ff);
      tag_hit   = (ent_rd_ff.csn != 64'd0) && (ent_rd_ff.tag == req_ff.slot_id);
      mark_next = (req_ff.slot_id == MARK_MAX) ? MARK_MAX : req_ff.slot_id + 63'd1;
      if (is_read) begin
         raise = !frozen && tag_hit && (ent_rd_ff.csn < req_ff.recycle_min);
      end else begin
         raise = is_final && (req_ff.record_csn < req_ff.recycle_min);
      end
      wm_new = (raise && (mark_next > wm_rd_ff)) ? mark_next : wm_rd_ff;
      store  = !is_read && (req_ff.keep_in_progress ||
                            (is_final && (req_ff.record_csn >= req_ff.recycle_min)));

      ent_new.csn    = req_ff.record_csn;
      ent_new.tag    = req_ff.record_tag;
      ent_new.status = req_ff.record_status;

      rsp_new.zone_watermark = wm_new;
      priority if (!is_read) begin
         rsp_new.hit          = 1'b1;
         rsp_new.found_status = req_ff.record_status;
         rsp_new.found_csn    = req_ff.record_csn;
         rsp_new.found_tag    = req_ff.record_tag;
      end else if (frozen) begin
         rsp_new.hit          = 1'b1;
         rsp_new.found_status = STATUS_FROZEN;
         rsp_new.found_csn    = 64'd0;
         rsp_new.found_tag    = req_ff.slot_id;
      end else if (tag_hit) begin
         rsp_new.hit          = 1'b1;
         rsp_new.found_status = ent_rd_ff.status;
         rsp_new.found_csn    = ent_rd_ff.csn;
         rsp_new.found_tag    = ent_rd_ff.tag;
      end else begin
         rsp_new.hit          = 1'b0;
         rsp_new.found_status = STATUS_IN_PROG;
         rsp_new.found_csn    = 64'd0;
         rsp_new.found_tag    = req_ff.slot_id;
      end
   end

   // write ports, clearing pass takes priority
   always_comb begin
      if (clear_ff) begin
         ent_wr_en   = 1'b1;
         ent_wr_addr = clear_cnt_ff;
         ent_wr_data = '0;
         wm_wr_en    = (clear_cnt_ff < ZONES_A);
         wm_wr_addr  = clear_cnt_ff[ZW-1:0];
         wm_wr_data  = '0;
      end else begin
         ent_wr_en   = eval_go && store;
         ent_wr_addr = addr_ff;
         ent_wr_data = ent_new;
         wm_wr_en    = eval_go;
         wm_wr_addr  = zone_ff;
         wm_wr_data  = wm_new;
      end
   end

   always_ff @(posedge clock) begin
      if (ent_wr_en) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      if (rd_en) begin
         ent_rd_ff <= ent_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wm_wr_en) begin
         wm_mem[wm_wr_addr] <= wm_wr_data;
      end
      if (rd_en) begin
         wm_rd_ff <= wm_mem[wm_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clear_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == LAST_ROW) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eval_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eval_go) begin
         rsp_data_ff <= rsp_new;
      end
   end

   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      (ent_wr_en && !clear_ff) |-> (state_ff == ST_EVAL && rsp_free))
      else $error("entry write outside write-back cycle");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("second transaction taken while one is in flight");

   a_eval_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      eval_go |=> rsp_valid_ff)
      else $error("finished transaction did not load the output register");

   a_stall_holds_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && !rsp_free) |=> (state_ff == ST_EVAL && $stable(ent_rd_ff)))
      else $error("read data lost during output stall");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (state_ff == ST_IDLE && !rsp_valid_ff))
      else $error("activity during clearing pass");

endmodule
